// ===== src/smx_pkg.sv =====
package smx_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 4;
    localparam int ST_W            = 4;
    localparam int STEP_W          = 5;
    localparam int STACK_DEPTH_DEF = 256;

    localparam logic [DATA_W-1:0] PRINT_CALL = DATA_W'(10);
    localparam logic [DATA_W-1:0] IP_STEP_1  = DATA_W'(1);
    localparam logic [DATA_W-1:0] IP_STEP_5  = DATA_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 4'd0,
        OP_ADD     = 4'd1,
        OP_SUB     = 4'd2,
        OP_MUL     = 4'd3,
        OP_DIV     = 4'd4,
        OP_ENVCALL = 4'd5,
        OP_JMP     = 4'd6,
        OP_HALT    = 4'd7,
        OP_BAD     = 4'd8
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 4'd0,
        ST_HALT      = 4'd1,
        ST_DIV_ZERO  = 4'd2,
        ST_BAD_OP    = 4'd3,
        ST_UNDERFLOW = 4'd4,
        ST_OVERFLOW  = 4'd5,
        ST_BAD_ECALL = 4'd6,
        ST_END       = 4'd7,
        ST_STOPPED   = 4'd8
    } t_status;

    // Microcode addresses
    typedef enum logic [STEP_W-1:0] {
        U_IDLE, U_STOPPED, U_END, U_PUSH, U_PUSH1, U_OVF,
        U_BIN, U_BIN0, U_BIN1, U_BIN2, U_BIN3, U_ADDSUB, U_MUL, U_MUL1,
        U_DIV, U_DIVW, U_DIVWR, U_DIVZ,
        U_ECALL, U_EC1, U_EC2, U_EC3, U_BADCALL,
        U_JMP, U_HALT, U_BADOP, U_UNDER, U_STOP, U_FINISH
    } t_step;

    // Sequencing: C_NEXT falls through, C_JUMP always branches, C_DISPATCH and
    // C_EMIT hold in place until their handshake allows, the rest branch when true.
    typedef enum logic [3:0] {
        C_NEXT, C_JUMP, C_DISPATCH, C_EMIT,
        C_FULL, C_LT2, C_LT1, C_NOT_PRINT, C_IS_MUL, C_IS_DIV, C_B_ZERO, C_DIV_BUSY
    } t_cond;

    typedef enum logic [1:0] {RD_NONE, RD_TOP, RD_NEXT} t_rd;
    typedef enum logic [2:0] {L_NONE, L_B, L_A, L_PV, L_MUL} t_ld;
    typedef enum logic [2:0] {WR_NONE, WR_ARG, WR_ALU, WR_MUL, WR_DIV} t_wr;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_DEC2} t_cnt;
    typedef enum logic [1:0] {IP_HOLD, IP_INC1, IP_INC5, IP_ARG} t_ipop;

    typedef struct packed {
        t_cond   cond;
        t_step   target;
        t_rd     rd;
        t_ld     ld;
        t_wr     wr;
        t_cnt    cnt;
        t_ipop   ip;
        t_status st;
        logic    stop;
        logic    div_start;
        logic    emit;
    } t_uword;

    function automatic t_step entry_step(input logic stopped, input logic at_end,
                                         input logic [OP_W-1:0] op);
        t_step s;
        if (stopped) begin
            s = U_STOPPED;
        end else if (at_end) begin
            s = U_END;
        end else begin
            unique case (op)
                OP_PUSH:                        s = U_PUSH;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: s = U_BIN;
                OP_ENVCALL:                     s = U_ECALL;
                OP_JMP:                         s = U_JMP;
                OP_HALT:                        s = U_HALT;
                default:                        s = U_BADOP;
            endcase
        end
        return s;
    endfunction

    // Control store: one word per step
    function automatic t_uword ucode(input t_step step);
        t_uword uw;
        uw           = t_uword'('0);
        uw.target    = U_FINISH;
        unique case (step)
            U_IDLE:    uw.cond = C_DISPATCH;
            U_STOPPED: begin uw.st = ST_STOPPED; uw.cond = C_JUMP; end
            U_END:     begin uw.st = ST_END; uw.stop = 1'b1; uw.cond = C_JUMP; end
            U_PUSH:    begin uw.ip = IP_INC5; uw.cond = C_FULL; uw.target = U_OVF; end
            U_PUSH1:   begin uw.wr = WR_ARG; uw.cnt = CNT_INC; uw.cond = C_JUMP; end
            U_OVF:     begin uw.st = ST_OVERFLOW; uw.cond = C_JUMP; uw.target = U_STOP; end
            U_BIN:     begin uw.ip = IP_INC1; uw.cond = C_LT2; uw.target = U_UNDER; end
            U_BIN0:    uw.rd = RD_TOP;
            U_BIN1:    begin uw.ld = L_B; uw.rd = RD_NEXT; end
            U_BIN2:    begin
                uw.ld     = L_A;
                uw.cnt    = CNT_DEC2;
                uw.cond   = C_IS_DIV;
                uw.target = U_DIV;
            end
            U_BIN3:    begin uw.cond = C_IS_MUL; uw.target = U_MUL; end
            U_ADDSUB:  begin uw.wr = WR_ALU; uw.cnt = CNT_INC; uw.cond = C_JUMP; end
            U_MUL:     uw.ld = L_MUL;
            U_MUL1:    begin uw.wr = WR_MUL; uw.cnt = CNT_INC; uw.cond = C_JUMP; end
            U_DIV:     begin
                uw.div_start = 1'b1;
                uw.cond      = C_B_ZERO;
                uw.target    = U_DIVZ;
            end
            U_DIVW:    begin uw.cond = C_DIV_BUSY; uw.target = U_DIVW; end
            U_DIVWR:   begin uw.wr = WR_DIV; uw.cnt = CNT_INC; uw.cond = C_JUMP; end
            U_DIVZ:    begin uw.st = ST_DIV_ZERO; uw.cond = C_JUMP; uw.target = U_STOP; end
            U_ECALL:   begin
                uw.ip     = IP_INC5;
                uw.cond   = C_NOT_PRINT;
                uw.target = U_BADCALL;
            end
            U_EC1:     begin uw.cond = C_LT1; uw.target = U_UNDER; end
            U_EC2:     begin uw.rd = RD_TOP; uw.cnt = CNT_DEC; end
            U_EC3:     begin uw.ld = L_PV; uw.cond = C_JUMP; end
            U_BADCALL: begin uw.st = ST_BAD_ECALL; uw.cond = C_JUMP; end
            U_JMP:     begin uw.ip = IP_ARG; uw.cond = C_JUMP; end
            U_HALT:    begin
                uw.ip     = IP_INC1;
                uw.st     = ST_HALT;
                uw.cond   = C_JUMP;
                uw.target = U_STOP;
            end
            U_BADOP:   begin
                uw.ip     = IP_INC1;
                uw.st     = ST_BAD_OP;
                uw.cond   = C_JUMP;
                uw.target = U_STOP;
            end
            U_UNDER:   begin uw.st = ST_UNDERFLOW; uw.cond = C_JUMP; uw.target = U_STOP; end
            U_STOP:    begin uw.stop = 1'b1; uw.cond = C_JUMP; end
            U_FINISH:  begin uw.emit = 1'b1; uw.cond = C_EMIT; uw.target = U_IDLE; end
            default:   begin uw.cond = C_JUMP; uw.target = U_IDLE; end
        endcase
        return uw;
    endfunction

endpackage

// ===== src/smx_divider.sv =====
module smx_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [smx_pkg::DATA_W-1:0]  i_dividend,
    input  logic signed [smx_pkg::DATA_W-1:0]  i_divisor,
    output logic                               o_busy,
    output logic signed [smx_pkg::DATA_W-1:0]  o_quotient
);
    import smx_pkg::*;

    localparam int SW = $clog2(DATA_W);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIX} t_dv_state;

    t_dv_state         r_state;
    logic [SW-1:0]     r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_div;
    logic              r_neg;

    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_comb begin
        mag_a   = i_dividend[DATA_W-1] ? (DATA_W'(0) - DATA_W'(i_dividend)) : DATA_W'(i_dividend);
        mag_b   = i_divisor[DATA_W-1] ? (DATA_W'(0) - DATA_W'(i_divisor)) : DATA_W'(i_divisor);
        shifted = {r_rem, r_quo[DATA_W-1]};
        diff    = shifted - {1'b0, r_div};
    end

    // Restoring divide, one quotient bit per cycle, sign applied at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else if (i_start) begin
            r_state <= DV_RUN;
            r_step  <= SW'(DATA_W - 1);
            r_rem   <= '0;
            r_quo   <= mag_a;
            r_div   <= mag_b;
            r_neg   <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else begin
            unique case (r_state)
                DV_RUN: begin
                    if (!diff[DATA_W]) begin
                        r_rem <= diff[DATA_W-1:0];
                        r_quo <= {r_quo[DATA_W-2:0], 1'b1};
                    end else begin
                        r_rem <= shifted[DATA_W-1:0];
                        r_quo <= {r_quo[DATA_W-2:0], 1'b0};
                    end
                    if (r_step == '0) begin
                        r_state <= DV_FIX;
                    end else begin
                        r_step <= r_step - SW'(1);
                    end
                end
                DV_FIX: begin
                    if (r_neg) begin
                        r_quo <= DATA_W'(0) - r_quo;
                    end
                    r_state <= DV_IDLE;
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_state != DV_IDLE);
    assign o_quotient = r_quo;

endmodule

// ===== src/stack_machine_executor_core.sv =====
// Executes one decoded stack-machine instruction per input transaction and returns one
// result transaction with the next instruction pointer, a status code and an optional
// print value. A small microcode sequencer steps a datapath around a stack memory with
// one read and one write port. Divide uses the restoring divider, which produces one
// quotient bit per cycle. While the output register is still stalled, the sequencer
// holds in its last step. A new instruction is taken while the previous result still
// waits at the output register.
module stack_machine_executor_core #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [smx_pkg::DATA_W-1:0]         i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [smx_pkg::OP_W-1:0]           i_req_type,
    input  logic signed [smx_pkg::DATA_W-1:0]  i_argument,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [smx_pkg::DATA_W-1:0]         o_next_ip,
    output logic [smx_pkg::ST_W-1:0]           o_status,
    output logic                               o_print_valid,
    output logic signed [smx_pkg::DATA_W-1:0]  o_print_value
);
    import smx_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Control state
    t_step             r_upc;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_ip;
    logic              r_stopped;
    logic [DATA_W-1:0] r_prog_size;
    logic              r_out_valid;

    // Datapath
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_arg;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] r_pv;
    logic              r_pvalid;
    t_status           r_status;
    logic [DATA_W-1:0] r_rd_q;
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];

    logic [DATA_W-1:0] r_o_ip;
    t_status           r_o_status;
    logic              r_o_pvalid;
    logic [DATA_W-1:0] r_o_pv;

    t_uword            uw;
    t_step             n_upc;
    t_step             seq_upc;
    logic              in_acc;
    logic              out_busy;
    logic              emit;
    logic              at_end;
    logic              cond_true;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] addsub;
    logic              div_start;
    logic              div_busy;
    logic [DATA_W-1:0] div_q;

    smx_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign o_in_stall = (r_upc != U_IDLE);

    always_comb begin
        uw        = ucode(r_upc);
        in_acc    = i_in_valid && !o_in_stall;
        out_busy  = r_out_valid && i_out_stall;
        emit      = uw.emit && !out_busy;
        at_end    = (r_ip >= r_prog_size);
        cnt_m1    = r_cnt - CW'(1);
        cnt_m2    = r_cnt - CW'(2);
        seq_upc   = t_step'(r_upc + STEP_W'(1));
        div_start = uw.div_start && (r_b != '0);
        addsub    = (r_op == OP_SUB) ? (r_a - r_b) : (r_a + r_b);

        unique case (uw.cond)
            C_FULL:      cond_true = (r_cnt == CW'(STACK_DEPTH));
            C_LT2:       cond_true = (r_cnt < CW'(2));
            C_LT1:       cond_true = (r_cnt == '0);
            C_NOT_PRINT: cond_true = (r_arg != PRINT_CALL);
            C_IS_MUL:    cond_true = (r_op == OP_MUL);
            C_IS_DIV:    cond_true = (r_op == OP_DIV);
            C_B_ZERO:    cond_true = (r_b == '0);
            C_DIV_BUSY:  cond_true = div_busy;
            default:     cond_true = 1'b0;
        endcase

        unique case (uw.cond)
            C_NEXT:     n_upc = seq_upc;
            C_JUMP:     n_upc = uw.target;
            C_DISPATCH: n_upc = in_acc ? entry_step(r_stopped, at_end, i_req_type) : r_upc;
            C_EMIT:     n_upc = out_busy ? r_upc : uw.target;
            default:    n_upc = cond_true ? uw.target : seq_upc;
        endcase

        rd_en = (uw.rd != RD_NONE);
        unique case (uw.rd)
            RD_NEXT: rd_addr = cnt_m2[AW-1:0];
            default: rd_addr = cnt_m1[AW-1:0];
        endcase

        wr_en = (uw.wr != WR_NONE);
        unique case (uw.wr)
            WR_ALU:  wr_data = addsub;
            WR_MUL:  wr_data = r_res;
            WR_DIV:  wr_data = div_q;
            default: wr_data = r_arg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_IDLE;
            r_cnt       <= '0;
            r_ip        <= '0;
            r_stopped   <= 1'b0;
            r_prog_size <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (i_cfg_wr_en) begin
                r_prog_size <= i_cfg_wr_data;
            end
            unique case (uw.cnt)
                CNT_INC:  r_cnt <= r_cnt + CW'(1);
                CNT_DEC:  r_cnt <= cnt_m1;
                CNT_DEC2: r_cnt <= cnt_m2;
                default:  r_cnt <= r_cnt;
            endcase
            unique case (uw.ip)
                IP_INC1: r_ip <= r_ip + IP_STEP_1;
                IP_INC5: r_ip <= r_ip + IP_STEP_5;
                IP_ARG:  r_ip <= r_arg;
                default: r_ip <= r_ip;
            endcase
            if (uw.stop) begin
                r_stopped <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_req_type;
            r_arg    <= i_argument;
            r_status <= ST_OK;
            r_pvalid <= 1'b0;
            r_pv     <= '0;
        end else begin
            if (uw.st != ST_OK) begin
                r_status <= uw.st;
            end
            unique case (uw.ld)
                L_A:     r_a <= r_rd_q;
                L_B:     r_b <= r_rd_q;
                L_MUL:   r_res <= r_a * r_b;
                L_PV:    begin
                    r_pv     <= r_rd_q;
                    r_pvalid <= 1'b1;
                end
                default: ;
            endcase
        end
        if (emit) begin
            r_o_ip     <= r_ip;
            r_o_status <= r_status;
            r_o_pvalid <= r_pvalid;
            r_o_pv     <= r_pv;
        end
    end

    // Operand stack
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[r_cnt[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_stack[rd_addr];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_ip     = r_o_ip;
    assign o_status      = r_o_status;
    assign o_print_valid = r_o_pvalid;
    assign o_print_value = r_o_pv;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_cnt < CW'(STACK_DEPTH)))
        else $error("stack write at full stack");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == U_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_print_valid) |-> (o_status == ST_OK))
        else $error("print value with non-ok status");
`endif

endmodule

// ===== sim/stack_machine_executor_checker.sv =====
`timescale 1ns / 1ps
module stack_machine_executor_checker
    import smx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [DATA_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [OP_W-1:0]   i_req_type,
    input  logic [DATA_W-1:0] i_argument,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [DATA_W-1:0] i_next_ip,
    input  logic [ST_W-1:0]   i_status,
    input  logic              i_print_valid,
    input  logic [DATA_W-1:0] i_print_value,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_prints,
    output int                o_unknown_calls
);

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] next_ip;
        logic [ST_W-1:0]   status;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
    } t_exec_result;

    logic [DATA_W-1:0] program_size = '0;
    logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
    int unsigned       depth = 0;
    logic [DATA_W-1:0] ip = '0;
    logic              halted = 1'b0;
    t_exec_result      expected_results [$];
    int                failures = 0;
    int                checked = 0;
    int                prints = 0;
    int                unknown_calls = 0;

    function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] num,
                                                               input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] q;
        num_mag = num[DATA_W-1] ? -num : num;
        den_mag = den[DATA_W-1] ? -den : den;
        q = num_mag / den_mag;
        return (num[DATA_W-1] != den[DATA_W-1]) ? -q : q;
    endfunction

    function automatic t_exec_result execute_instruction(input logic [OP_W-1:0] op,
                                                         input logic [DATA_W-1:0] arg);
        t_exec_result      res;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] value;
        res = '0;
        if (halted) begin
            res.status = ST_STOPPED;
        end else if (ip >= program_size) begin
            // not executed, pointer stays where it is
            res.status = ST_END;
            halted = 1'b1;
        end else begin
            res.next_ip = ip + IP_STEP_1;
            case (op)
                OP_PUSH: begin
                    res.next_ip = ip + IP_STEP_5;
                    if (depth >= STACK_DEPTH) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        operand_mem[depth] = arg;
                        depth++;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (depth < 2) begin
                        res.status = ST_UNDERFLOW;
                    end else begin
                        rhs = operand_mem[depth-1];
                        lhs = operand_mem[depth-2];
                        depth -= 2;
                        // both operands are gone even when the divisor is zero
                        if (op == OP_DIV && rhs == '0) begin
                            res.status = ST_DIV_ZERO;
                        end else begin
                            case (op)
                                OP_ADD:  value = lhs + rhs;
                                OP_SUB:  value = lhs - rhs;
                                OP_MUL:  value = lhs * rhs;
                                default: value = quotient_toward_zero(lhs, rhs);
                            endcase
                            operand_mem[depth] = value;
                            depth++;
                        end
                    end
                end
                OP_ENVCALL: begin
                    res.next_ip = ip + IP_STEP_5;
                    if (arg != PRINT_CALL) begin
                        res.status = ST_BAD_ECALL;
                    end else if (depth < 1) begin
                        res.status = ST_UNDERFLOW;
                    end else begin
                        depth--;
                        res.print_valid = 1'b1;
                        res.print_value = operand_mem[depth];
                    end
                end
                OP_JMP:  res.next_ip = arg;
                OP_HALT: res.status = ST_HALT;
                default: res.status = ST_BAD_OP;
            endcase
            ip = res.next_ip;
            if (res.status != ST_OK && res.status != ST_BAD_ECALL) halted = 1'b1;
        end
        res.next_ip = ip;
        return res;
    endfunction

    function automatic void note_mismatch(input string msg);
        if (failures < 10) $display("%s", msg);
        failures++;
    endfunction

    always @(posedge i_clk) begin
        t_exec_result want;
        if (!i_rst_n) begin
            program_size = '0;
            depth = 0;
            ip = '0;
            halted = 1'b0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) program_size = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(execute_instruction(i_req_type, i_argument));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected result transaction: next_ip %h status %0d print %b %h",
                        i_next_ip, i_status, i_print_valid, i_print_value));
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.print_valid) prints++;
                    if (want.status == ST_BAD_ECALL) unknown_calls++;
                    if (i_next_ip !== want.next_ip || i_status !== want.status ||
                        i_print_valid !== want.print_valid ||
                        i_print_value !== want.print_value) begin
                        note_mismatch($sformatf(
                            "result %0d: expected next_ip %h status %0d print %b %h, got %h %0d %b %h",
                            checked, want.next_ip, want.status, want.print_valid,
                            want.print_value, i_next_ip, i_status, i_print_valid,
                            i_print_value));
                    end
                end
            end
            o_pending <= expected_results.size();
        end
        o_fail_count <= failures;
        o_checked <= checked;
        o_prints <= prints;
        o_unknown_calls <= unknown_calls;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import smx_pkg::*;

    localparam int unsigned     CYCLE_LIMIT  = 1_000_000;
    localparam int              RANDOM_ITEMS = 1400;
    localparam int              HOLD_CYCLES  = 400;
    localparam int              DRAIN_CYCLES = 60;
    localparam logic [DATA_W-1:0] SIZE_MAX   = '1;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [DATA_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic [OP_W-1:0]   req_type = '0;
    logic [DATA_W-1:0] argument = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [DATA_W-1:0] next_ip;
    logic [ST_W-1:0]   status;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;

    int failures;
    int pending_results;
    int results_checked;
    int prints_seen;
    int unknown_calls;

    // stimulus-side bookkeeping, used to keep the program running and for the final report
    logic [DATA_W-1:0] prog_size = '0;
    logic [DATA_W-1:0] prog_ip = '0;
    int                stack_depth = 0;
    int                peak_depth = 0;
    t_status           stop_status = ST_OK;

    logic              quiet = 1'b0;
    logic              hold_armed = 1'b0;
    logic              hold_served = 1'b0;
    int                hold_left = 0;
    int unsigned       cycle_count = 0;

    stack_machine_executor_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_argument    (argument),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_next_ip     (next_ip),
        .o_status      (status),
        .o_print_valid (print_valid),
        .o_print_value (print_value)
    );

    stack_machine_executor_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_argument      (argument),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_next_ip       (next_ip),
        .i_status        (status),
        .i_print_valid   (print_valid),
        .i_print_value   (print_value),
        .o_fail_count    (failures),
        .o_pending       (pending_results),
        .o_checked       (results_checked),
        .o_prints        (prints_seen),
        .o_unknown_calls (unknown_calls)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stack_machine_executor_core: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off to back up the block.
    always @(posedge clk) begin
        if (hold_armed && !hold_served) begin
            hold_served <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !quiet && ($urandom_range(99) < 32);
        end
    end

    function automatic logic [DATA_W-1:0] ip_after(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] arg);
        case (op)
            OP_PUSH, OP_ENVCALL: return prog_ip + IP_STEP_5;
            OP_JMP:              return arg;
            default:             return prog_ip + IP_STEP_1;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_divisor();
        case ($urandom_range(5))
            0:       return 32'h0000_0001;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(15, 2);
            3:       return 32'h8000_0000;
            default: return $urandom_range(32'hFFFF_FFFF, 1);
        endcase
    endfunction

    // Drive one transaction and hold it until the block takes it.
    task automatic present_instruction(input logic [OP_W-1:0] op,
                                       input logic [DATA_W-1:0] arg);
        while (!quiet && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        argument <= arg;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Jump back into the program first when this instruction would run off its end.
    task automatic issue_instruction(input logic [OP_W-1:0] op,
                                     input logic [DATA_W-1:0] arg);
        logic [DATA_W-1:0] hop;
        if (ip_after(op, arg) >= prog_size) begin
            hop = $urandom_range(prog_size - 6, 0);
            present_instruction(OP_JMP, hop);
            prog_ip = hop;
        end
        present_instruction(op, arg);
        prog_ip = ip_after(op, arg);
        case (op)
            OP_PUSH: if (stack_depth < STACK_DEPTH_DEF) stack_depth++;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (stack_depth >= 2) stack_depth--;
            OP_ENVCALL: if (arg == PRINT_CALL && stack_depth != 0) stack_depth--;
            default: ;
        endcase
        if (stack_depth > peak_depth) peak_depth = stack_depth;
    endtask

    task automatic issue_random_instruction(input bit grow);
        int              pick;
        int              kind;
        logic [OP_W-1:0] alu;
        logic [DATA_W-1:0] call;
        pick = $urandom_range(99);
        if (grow) begin
            kind = (pick < 55) ? 0 : (pick < 75) ? 1 : (pick < 83) ? 2 :
                   (pick < 90) ? 3 : (pick < 94) ? 4 : 5;
        end else begin
            kind = (pick < 15) ? 0 : (pick < 55) ? 1 : (pick < 67) ? 2 :
                   (pick < 87) ? 3 : (pick < 92) ? 4 : 5;
        end
        case ($urandom_range(2))
            0:       alu = OP_ADD;
            1:       alu = OP_SUB;
            default: alu = OP_MUL;
        endcase
        if (kind == 0 && stack_depth >= STACK_DEPTH_DEF) kind = 1;
        if ((kind == 1 && stack_depth < 2) || (kind == 3 && stack_depth == 0)) kind = 0;
        case (kind)
            0: issue_instruction(OP_PUSH, pick_operand());
            1: issue_instruction(alu, $urandom);
            2: begin
                if (stack_depth == 0) issue_instruction(OP_PUSH, pick_operand());
                if (stack_depth >= STACK_DEPTH_DEF) issue_instruction(alu, $urandom);
                issue_instruction(OP_PUSH, pick_divisor());
                issue_instruction(OP_DIV, $urandom);
            end
            3: issue_instruction(OP_ENVCALL, PRINT_CALL);
            4: begin
                call = $urandom;
                if (call == PRINT_CALL) call = '0;
                issue_instruction(OP_ENVCALL, call);
            end
            default: begin
                if (prog_size == SIZE_MAX && $urandom_range(7) == 0) begin
                    issue_instruction(OP_JMP, $urandom_range(32'hFFFF_FFFE, 32'hFFFF_FFF0));
                end else begin
                    issue_instruction(OP_JMP, $urandom_range(prog_size - 1, 0));
                end
            end
        endcase
    endtask

    // Write the register once every result is back.
    task automatic set_program_size(input logic [DATA_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        prog_size = value;
    endtask

    task automatic restart_at_size(input logic [DATA_W-1:0] value);
        issue_instruction(OP_JMP, '0);
        set_program_size(value);
    endtask

    initial begin
        bit grow;
        int keep;
        grow = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_program_size(SIZE_MAX);

        // arithmetic wrap, divide corners, calls and pointer wrap
        issue_instruction(OP_PUSH, 32'h7FFF_FFFF);
        issue_instruction(OP_PUSH, 32'h0000_0001);
        issue_instruction(OP_ADD, '0);
        issue_instruction(OP_PUSH, 32'hFFFF_FFFF);
        issue_instruction(OP_DIV, 32'hFFFF_FFFF);
        issue_instruction(OP_ENVCALL, PRINT_CALL);
        issue_instruction(OP_PUSH, 32'h8000_0000);
        issue_instruction(OP_PUSH, 32'h0000_0001);
        issue_instruction(OP_SUB, 32'hFFFF_FFFF);
        issue_instruction(OP_PUSH, 32'h0001_0000);
        issue_instruction(OP_PUSH, 32'h0001_0000);
        issue_instruction(OP_MUL, '0);
        issue_instruction(OP_PUSH, 32'hFFFF_FFF9);
        issue_instruction(OP_PUSH, 32'h0000_0002);
        issue_instruction(OP_DIV, '0);
        issue_instruction(OP_PUSH, 32'h0000_0007);
        issue_instruction(OP_PUSH, 32'hFFFF_FFFE);
        issue_instruction(OP_DIV, '0);
        issue_instruction(OP_ENVCALL, PRINT_CALL);
        issue_instruction(OP_ENVCALL, '0);
        issue_instruction(OP_ENVCALL, 32'hFFFF_FFFF);
        issue_instruction(OP_ENVCALL, 32'h0000_000B);
        issue_instruction(OP_JMP, 32'hFFFF_FFFC);
        issue_instruction(OP_PUSH, '0);
        issue_instruction(OP_JMP, 32'h0000_0100);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) == 0) grow = !grow;
            case (n)
                300: hold_armed <= 1'b1;
                500: begin
                    restart_at_size(32'h0000_0001);
                    repeat (6) issue_instruction(OP_JMP, '0);
                    set_program_size($urandom_range(200, 64));
                end
                800: quiet <= 1'b1;
                1000: begin
                    quiet <= 1'b0;
                    restart_at_size($urandom_range(32'h7FFF_FFFF, 1000));
                end
                1100: while (stack_depth < STACK_DEPTH_DEF) issue_instruction(OP_PUSH, pick_operand());
                1200: restart_at_size(32'h8000_0000);
                1300: restart_at_size(SIZE_MAX);
                default: ;
            endcase
            issue_random_instruction(grow);
        end

        // Reset comes only once, so one stopping case ends the program per run.
        restart_at_size(SIZE_MAX);
        case ($urandom_range(7))
            0: begin
                stop_status = ST_HALT;
                issue_instruction(OP_HALT, $urandom);
            end
            1: begin
                stop_status = ST_DIV_ZERO;
                if (stack_depth == 0) issue_instruction(OP_PUSH, pick_operand());
                if (stack_depth >= STACK_DEPTH_DEF) issue_instruction(OP_ADD, '0);
                issue_instruction(OP_PUSH, '0);
                issue_instruction(OP_DIV, $urandom);
            end
            2: begin
                stop_status = ST_BAD_OP;
                issue_instruction(OP_BAD, $urandom);
            end
            3: begin
                stop_status = ST_BAD_OP;
                issue_instruction(OP_BAD | 4'($urandom_range(7, 1)), $urandom);
            end
            4: begin
                stop_status = ST_UNDERFLOW;
                keep = $urandom_range(1);
                while (stack_depth > keep) issue_instruction(OP_ENVCALL, PRINT_CALL);
                issue_instruction(OP_SUB, $urandom);
            end
            5: begin
                stop_status = ST_UNDERFLOW;
                while (stack_depth > 0) issue_instruction(OP_ENVCALL, PRINT_CALL);
                issue_instruction(OP_ENVCALL, PRINT_CALL);
            end
            6: begin
                stop_status = ST_OVERFLOW;
                while (stack_depth < STACK_DEPTH_DEF) issue_instruction(OP_PUSH, pick_operand());
                issue_instruction(OP_PUSH, pick_operand());
            end
            default: begin
                stop_status = ST_END;
                set_program_size('0);
                present_instruction(4'($urandom_range(15)), $urandom);
            end
        endcase
        set_program_size('0);
        // everything from here on is answered as stopped
        repeat (40) present_instruction(4'($urandom_range(15)), $urandom);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d printed values, %0d unknown calls, stack peak %0d",
                 results_checked, prints_seen, unknown_calls, peak_depth);
        $display("Program sizes 0, 1, small, mid and full range; program stopped by %s",
                 stop_status.name());
        if (failures == 0 && pending_results == 0) begin
            $display("stack_machine_executor_core: match");
        end else begin
            $display("stack_machine_executor_core: mismatch");
        end
        $finish;
    end

endmodule
